// ===== rtl/core/html_tag_tokenizer_assert.svh =====
// Assertion macros used by the tokenizer checker.
`ifndef HTML_TAG_TOKENIZER_ASSERT_SVH
`define HTML_TAG_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("html_tag_tokenizer: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define HTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("html_tag_tokenizer: next-cycle check failed");

`endif

// ===== rtl/core/htt_pkg.sv =====
// ----------------------------------------------------------------------------
// htt_pkg
// Types, mode codes, character constants and helpers of the HTML tag tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htt_pkg;

  // Token kinds
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_SELF  = 2'd3;

  // Tokenizer modes
  localparam logic [4:0] MODE_DATA       = 5'd0;
  localparam logic [4:0] MODE_TEXT       = 5'd1;
  localparam logic [4:0] MODE_LT         = 5'd2;
  localparam logic [4:0] MODE_LT_SLASH   = 5'd3;
  localparam logic [4:0] MODE_TAG_NAME   = 5'd4;
  localparam logic [4:0] MODE_BEFORE     = 5'd5;
  localparam logic [4:0] MODE_SELF       = 5'd6;
  localparam logic [4:0] MODE_ATTR_NAME  = 5'd7;
  localparam logic [4:0] MODE_AFTER_NAME = 5'd8;
  localparam logic [4:0] MODE_AFTER_EQ   = 5'd9;
  localparam logic [4:0] MODE_VAL_DQ     = 5'd10;
  localparam logic [4:0] MODE_VAL_SQ     = 5'd11;
  localparam logic [4:0] MODE_VAL_UNQ    = 5'd12;
  localparam logic [4:0] MODE_BANG       = 5'd13;
  localparam logic [4:0] MODE_BANG_DASH  = 5'd14;
  localparam logic [4:0] MODE_COMMENT    = 5'd15;
  localparam logic [4:0] MODE_DECL       = 5'd16;
  localparam logic [4:0] MODE_RAW        = 5'd17;
  localparam logic [4:0] MODE_RAW_TAIL   = 5'd18;

  // Raw-text element kinds
  localparam logic [1:0] RAW_SCRIPT   = 2'd0;
  localparam logic [1:0] RAW_STYLE    = 2'd1;
  localparam logic [1:0] RAW_NOSCRIPT = 2'd2;

  // Characters
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;

  // Element names, left aligned, zero padded
  localparam logic [63:0] NAME_SCRIPT   = {"script", 16'h0000};
  localparam logic [63:0] NAME_STYLE    = {"style", 24'h000000};
  localparam logic [63:0] NAME_NOSCRIPT = "noscript";

  // One emitted token
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] raw_start;
    logic [31:0] raw_length;
    logic [31:0] nm_start;
    logic [31:0] name_length;
    logic [31:0] attrs_start;
    logic [31:0] attrs_length;
    logic        run_last;
  } token_t;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SP, CH_TAB, CH_LF, CH_CR, CH_FF};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
  endfunction

  // Name length; an out-of-range kind falls back to script
  function automatic logic [3:0] special_len(input logic [1:0] kind);
    logic [3:0] len;
    case (kind)
      RAW_STYLE:    len = 4'd5;
      RAW_NOSCRIPT: len = 4'd8;
      default:      len = 4'd6;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] special_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [63:0] word;
    case (kind)
      RAW_STYLE:    word = NAME_STYLE;
      RAW_NOSCRIPT: word = NAME_NOSCRIPT;
      default:      word = NAME_SCRIPT;
    endcase
    return word[63 - 8 * int'(idx) -: 8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/htt_core.sv =====
// ----------------------------------------------------------------------------
// htt_core
// Tokenizer state and single-pass next-state logic; up to two tokens per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htt_core import htt_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output logic [1:0]      tok_cnt_o,
  output token_t          tok0_o,
  output token_t          tok1_o
);

  typedef logic [OFFSET_BITS-1:0] off_t;

  // State registers
  logic [4:0] mode_q, mode_d;
  off_t       pos_q, pos_d;
  off_t       tb_q, tb_d;
  off_t       nb_q, nb_d;
  off_t       nl_q, nl_d;
  off_t       ab_q, ab_d;
  logic       seen_q, seen_d;
  logic       ie_q, ie_d;
  logic [2:0] match_q, match_d;
  logic [1:0] rk_q, rk_d;
  logic [3:0] cmc_q, cmc_d;
  logic [1:0] dash_q, dash_d;

  // Step control
  off_t       p, p_inc, nl_base;
  logic [2:0] match_base;
  logic       go_data, go_name, name_fresh, go_before, go_unq, go_decl;
  logic       do_mark, do_close, close_self, raw_hit;
  logic [1:0] raw_kind;
  logic       push_s, push_l;
  token_t     tok_s, tok_l;
  logic [3:0] rlen, rc;
  logic [7:0] want;
  logic       lt, gt, slash, eqc, blk;

  function automatic token_t make_text(input off_t start, input off_t len);
    token_t t;
    t            = '0;
    t.kind       = KIND_TEXT;
    t.raw_start  = 32'(start);
    t.raw_length = 32'(len);
    return t;
  endfunction

  function automatic token_t make_tag(input logic [1:0] kind, input off_t tb, input off_t nb,
                                      input off_t nl, input logic seen, input off_t ab,
                                      input off_t raw_end, input off_t attrs_stop);
    token_t t;
    t             = '0;
    t.kind        = kind;
    t.raw_start   = 32'(tb);
    t.raw_length  = 32'(off_t'(raw_end - tb));
    t.nm_start    = 32'(nb);
    t.name_length = 32'(nl);
    if (seen && (ab < attrs_stop)) begin
      t.attrs_start  = 32'(ab);
      t.attrs_length = 32'(off_t'(attrs_stop - ab));
    end
    return t;
  endfunction

  assign lt    = (byte_i == CH_LT);
  assign gt    = (byte_i == CH_GT);
  assign slash = (byte_i == CH_SLASH);
  assign eqc   = (byte_i == CH_EQ);
  assign blk   = is_blank(byte_i);
  assign p     = pos_q;
  assign p_inc = p + off_t'(1);

  // Next state and tokens for the byte at the input register
  always_comb begin
    mode_d = mode_q;  pos_d = pos_q;  tb_d = tb_q;  nb_d = nb_q;  nl_d = nl_q;
    ab_d = ab_q;  seen_d = seen_q;  ie_d = ie_q;  match_d = match_q;  rk_d = rk_q;
    cmc_d = cmc_q;  dash_d = dash_q;
    go_data = 1'b0;  go_name = 1'b0;  name_fresh = 1'b0;  go_before = 1'b0;
    go_unq = 1'b0;  go_decl = 1'b0;  do_mark = 1'b0;  do_close = 1'b0;
    close_self = 1'b0;  raw_hit = 1'b0;  raw_kind = RAW_SCRIPT;
    push_s = 1'b0;  push_l = 1'b0;  tok_s = '0;  tok_l = '0;
    nl_base = nl_q;  match_base = match_q;
    rlen = '0;  rc = '0;  want = '0;

    case (mode_q)
      MODE_TEXT: begin
        if (lt) begin
          push_s = 1'b1;
          tok_s  = make_text(tb_q, p - tb_q);
          tb_d   = p;
          mode_d = MODE_LT;
        end
      end
      MODE_LT: begin
        if (slash) begin
          ie_d = 1'b1;  mode_d = MODE_LT_SLASH;
        end else if (byte_i == CH_BANG) begin
          mode_d = MODE_BANG;
        end else if (is_letter(byte_i)) begin
          ie_d = 1'b0;  go_name = 1'b1;  name_fresh = 1'b1;
        end else begin
          push_s = 1'b1;  tok_s = make_text(tb_q, off_t'(1));  go_data = 1'b1;
        end
      end
      MODE_LT_SLASH: begin
        if (is_letter(byte_i)) begin
          go_name = 1'b1;  name_fresh = 1'b1;
        end else begin
          push_s = 1'b1;  tok_s = make_text(tb_q, off_t'(2));  go_data = 1'b1;
        end
      end
      MODE_TAG_NAME: begin
        if (blk || gt || slash) go_before = 1'b1;
        else                    go_name = 1'b1;
      end
      MODE_BEFORE: go_before = 1'b1;
      MODE_SELF: begin
        if (gt) begin
          do_close = 1'b1;  close_self = 1'b1;
        end else begin
          go_before = 1'b1;
        end
      end
      MODE_ATTR_NAME: begin
        if (eqc) begin
          do_mark = 1'b1;  mode_d = MODE_AFTER_EQ;
        end else if (blk) begin
          mode_d = MODE_AFTER_NAME;
        end else if (gt || slash) begin
          go_before = 1'b1;
        end else begin
          do_mark = 1'b1;
        end
      end
      MODE_AFTER_NAME: begin
        if (blk) begin
          mode_d = MODE_AFTER_NAME;
        end else if (eqc) begin
          do_mark = 1'b1;  mode_d = MODE_AFTER_EQ;
        end else if (gt || slash) begin
          go_before = 1'b1;
        end else begin
          do_mark = 1'b1;  mode_d = MODE_ATTR_NAME;
        end
      end
      MODE_AFTER_EQ: begin
        if (byte_i == CH_DQ) begin
          do_mark = 1'b1;  mode_d = MODE_VAL_DQ;
        end else if (byte_i == CH_SQ) begin
          do_mark = 1'b1;  mode_d = MODE_VAL_SQ;
        end else begin
          go_unq = 1'b1;
        end
      end
      MODE_VAL_DQ: begin
        do_mark = 1'b1;
        if (byte_i == CH_DQ) mode_d = MODE_BEFORE;
      end
      MODE_VAL_SQ: begin
        do_mark = 1'b1;
        if (byte_i == CH_SQ) mode_d = MODE_BEFORE;
      end
      MODE_VAL_UNQ: go_unq = 1'b1;
      MODE_BANG: begin
        if (byte_i == CH_DASH) mode_d = MODE_BANG_DASH;
        else                   go_decl = 1'b1;
      end
      MODE_BANG_DASH: begin
        if (byte_i == CH_DASH) begin
          dash_d = '0;  mode_d = MODE_COMMENT;
        end else begin
          go_decl = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (byte_i == CH_DASH) begin
          if (dash_q < 2'd2) dash_d = dash_q + 2'd1;
        end else if (gt && (dash_q == 2'd2)) begin
          dash_d = '0;  mode_d = MODE_DATA;
        end else begin
          dash_d = '0;
        end
      end
      MODE_DECL: go_decl = 1'b1;
      MODE_RAW: begin
        // close-tag matcher: '<', '/', then the element name, case-blind
        rlen = special_len(rk_q) + 4'd2;
        rc   = (cmc_q >= rlen) ? 4'd0 : cmc_q;
        if (rc == 4'd0)      want = CH_LT;
        else if (rc == 4'd1) want = CH_SLASH;
        else                 want = special_char(rk_q, 3'(rc - 4'd2));
        if (to_lower(byte_i) == want) rc = rc + 4'd1;
        else                          rc = lt ? 4'd1 : 4'd0;
        if (rc >= rlen) begin
          rc = '0;  mode_d = MODE_RAW_TAIL;
        end
        cmc_d = rc;
      end
      MODE_RAW_TAIL: begin
        if (gt) mode_d = MODE_DATA;
      end
      default: go_data = 1'b1;
    endcase

    // Unquoted value byte, may fall through to the before-attribute handling
    if (go_unq) begin
      if (blk || gt) go_before = 1'b1;
      else begin
        do_mark = 1'b1;  mode_d = MODE_VAL_UNQ;
      end
    end

    // Declaration byte
    if (go_decl) mode_d = gt ? MODE_DATA : MODE_DECL;

    // Before-attribute handling
    if (go_before) begin
      if (blk) begin
        mode_d = MODE_BEFORE;
      end else if (gt) begin
        do_close = 1'b1;
      end else if (slash) begin
        do_mark = 1'b1;  mode_d = MODE_SELF;
      end else begin
        do_mark = 1'b1;  mode_d = MODE_ATTR_NAME;
      end
    end

    // First non-blank attribute byte
    if (do_mark && !blk && !seen_q) begin
      seen_d = 1'b1;  ab_d = p;
    end

    // Data byte: start text or a tag
    if (go_data) begin
      tb_d   = p;
      mode_d = lt ? MODE_LT : MODE_TEXT;
    end

    // Tag-name byte, optionally opening a fresh name
    if (go_name) begin
      if (name_fresh) begin
        nb_d = p;  nl_base = '0;  match_base = 3'b111;  seen_d = 1'b0;  ab_d = '0;
      end
      match_d = match_base;
      for (int i = 0; i < 3; i++) begin
        if ((nl_base >= off_t'(special_len(2'(i)))) ||
            (to_lower(byte_i) != special_char(2'(i), nl_base[2:0])))
          match_d[i] = 1'b0;
      end
      nl_d   = nl_base + off_t'(1);
      mode_d = MODE_TAG_NAME;
    end

    // Tag close: raw-text element or a tag token
    if (do_close) begin
      if (!close_self && !ie_q) begin
        for (int i = 2; i >= 0; i--) begin
          if (match_q[i] && (nl_q == off_t'(special_len(2'(i))))) begin
            raw_hit  = 1'b1;
            raw_kind = 2'(i);
          end
        end
      end
      if (raw_hit) begin
        rk_d = raw_kind;  cmc_d = '0;  mode_d = MODE_RAW;
      end else begin
        push_s = 1'b1;
        tok_s  = make_tag(close_self ? KIND_SELF : (ie_q ? KIND_END : KIND_START),
                          tb_q, nb_q, nl_q, seen_q, ab_q, p_inc,
                          close_self ? (p - off_t'(1)) : p);
        mode_d = MODE_DATA;
      end
    end

    // Final byte: flush what is pending and restart
    if (last_i) begin
      case (mode_d)
        MODE_TEXT: begin
          push_l = 1'b1;  tok_l = make_text(tb_d, p_inc - tb_d);
        end
        MODE_LT: begin
          push_l = 1'b1;  tok_l = make_text(tb_d, off_t'(1));
        end
        MODE_LT_SLASH: begin
          push_l = 1'b1;  tok_l = make_text(tb_d, off_t'(2));
        end
        default: begin
          if (mode_d inside {[MODE_TAG_NAME:MODE_VAL_UNQ]}) begin
            push_l = 1'b1;
            tok_l  = make_tag(ie_d ? KIND_END : KIND_START, tb_d, nb_d, nl_d, seen_d, ab_d,
                              p_inc, p_inc);
          end
        end
      endcase
      mode_d = MODE_DATA;  dash_d = '0;  cmc_d = '0;  pos_d = '0;
    end else begin
      pos_d = p_inc;
    end
  end

  // Pack the tokens; the last one of the byte carries run_last
  always_comb begin
    tok0_o    = push_s ? tok_s : tok_l;
    tok1_o    = tok_l;
    tok_cnt_o = 2'(push_s) + 2'(push_l);
    tok0_o.run_last = !(push_s && push_l);
    tok1_o.run_last = 1'b1;
  end

  // State update on each stepped byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DATA;  pos_q <= '0;  tb_q <= '0;  nb_q <= '0;  nl_q <= '0;
      ab_q <= '0;  seen_q <= 1'b0;  ie_q <= 1'b0;  match_q <= 3'b111;
      rk_q <= RAW_SCRIPT;  cmc_q <= '0;  dash_q <= '0;
    end else if (en_i) begin
      mode_q <= mode_d;  pos_q <= pos_d;  tb_q <= tb_d;  nb_q <= nb_d;  nl_q <= nl_d;
      ab_q <= ab_d;  seen_q <= seen_d;  ie_q <= ie_d;  match_q <= match_d;
      rk_q <= rk_d;  cmc_q <= cmc_d;  dash_q <= dash_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/html_tag_tokenizer.sv =====
// ----------------------------------------------------------------------------
// html_tag_tokenizer
// Streaming HTML tag tokenizer: one document byte in, offset/length tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: byte_in_i/last_byte_i with in_valid_i/in_stall_o. A transfer
//   happens when in_valid_i is high and in_stall_o is low. Set last_byte_i on
//   the final byte of a document; the next byte starts a new document at 0.
//   Output channel: token fields with out_valid_o/out_stall_i, one token per
//   transfer. run_last_o marks the last token produced by a byte.
//   Flow: a byte taken into the input register is processed when that register
//   advances; its tokens are then written to the token queue and offered from it.
//   Throughput: one byte per cycle while the receiver keeps up. A byte yields at
//   most two tokens; the four-entry token queue must have two free entries for
//   the processing register to advance.
//   Stall: when the receiver stalls the queue fills and in_stall_o rises; the
//   head token holds steady until it is taken.
//   Reset: clears the tokenizer state to data mode at offset 0 and empties both
//   the input register and the token queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module html_tag_tokenizer import htt_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       token_kind_o,
  output logic [31:0]      raw_start_o,
  output logic [31:0]      raw_length_o,
  output logic [31:0]      tag_name_start_o,
  output logic [31:0]      tag_name_length_o,
  output logic [31:0]      attrs_start_o,
  output logic [31:0]      attrs_length_o,
  output logic             run_last_o
);

  localparam int QDEPTH = 4;
  localparam int QPTR   = $clog2(QDEPTH);

  logic            in_vld_q;
  logic [7:0]      byte_q;
  logic            last_q;
  logic            in_acc, adv, pop;
  logic [1:0]      tok_cnt, push_n;
  token_t          tok0, tok1, head;
  token_t          fifo_q [QDEPTH];
  logic [QPTR-1:0] wr_q, rd_q;
  logic [QPTR:0]   cnt_q;

  // Input register handshake
  assign adv        = in_vld_q && (cnt_q <= (QPTR+1)'(QDEPTH - 2));
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= byte_in_i;
      last_q <= last_byte_i;
    end
  end

  // Tokenizer step
  htt_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .byte_i   (byte_q),
    .last_i   (last_q),
    .tok_cnt_o(tok_cnt),
    .tok0_o   (tok0),
    .tok1_o   (tok1)
  );

  // Token queue
  assign push_n = adv ? tok_cnt : 2'd0;
  assign pop    = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) fifo_q[wr_q] <= tok0;
    if (push_n == 2'd2) fifo_q[wr_q + QPTR'(1)] <= tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPTR'(push_n);
      rd_q  <= rd_q + QPTR'(pop);
      cnt_q <= cnt_q + (QPTR+1)'(push_n) - (QPTR+1)'(pop);
    end
  end

  // Output port
  assign head              = fifo_q[rd_q];
  assign out_valid_o       = (cnt_q != '0);
  assign token_kind_o      = head.kind;
  assign raw_start_o       = head.raw_start;
  assign raw_length_o      = head.raw_length;
  assign tag_name_start_o  = head.nm_start;
  assign tag_name_length_o = head.name_length;
  assign attrs_start_o     = head.attrs_start;
  assign attrs_length_o    = head.attrs_length;
  assign run_last_o        = head.run_last;

endmodule

`default_nettype wire

// ===== rtl/core/htt_sva.sv =====
// ----------------------------------------------------------------------------
// htt_sva
// Port-level checks of the HTML tag tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "html_tag_tokenizer_assert.svh"

module htt_sva import htt_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  token_kind_o,
  input wire logic [31:0] raw_start_o,
  input wire logic [31:0] raw_length_o,
  input wire logic [31:0] tag_name_start_o,
  input wire logic [31:0] tag_name_length_o,
  input wire logic [31:0] attrs_start_o,
  input wire logic [31:0] attrs_length_o,
  input wire logic        run_last_o
);

  logic [194:0] out_bus;
  logic         out_held;
  logic         text_tok;
  logic         no_spans;

  // Offered token as one vector
  assign out_bus  = {token_kind_o, raw_start_o, raw_length_o, tag_name_start_o,
                     tag_name_length_o, attrs_start_o, attrs_length_o, run_last_o};
  assign out_held = out_valid_o && out_stall_i;
  assign text_tok = out_valid_o && (token_kind_o == KIND_TEXT);
  assign no_spans = (tag_name_start_o == 32'd0) && (tag_name_length_o == 32'd0) &&
                    (attrs_start_o == 32'd0) && (attrs_length_o == 32'd0);

  // A stalled token stays offered
  `HTT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o)

  // A stalled token does not change
  `HTT_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_held, $stable(out_bus))

  // With the token queue empty the input never stalls
  `HTT_ASSERT_NOW(a_no_idle_stall, clk_i, rst_ni, !out_valid_o, !in_stall_o)

  // Text tokens carry no name or attribute span
  `HTT_ASSERT_NOW(a_text_spans, clk_i, rst_ni, text_tok, no_spans)

endmodule

bind html_tag_tokenizer htt_sva u_htt_sva (.*);

`default_nettype wire
